// ===== hdl/accel_tilt_angles_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tilt angle block
// Clocked, reset-qualified implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLES_ASSERT_SVH
`define ACCEL_TILT_ANGLES_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define ATA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tilt angle check failed");

// Next-cycle implication, checked while out of reset.
`define ATA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tilt angle check failed");

`endif

// ===== hdl/ata_pkg.sv =====
// ----------------------------------------------------------------------------
// ata_pkg
// Types, constants and the arctangent table shared by the tilt angle block.
// ----------------------------------------------------------------------------
package ata_pkg;

    // CORDIC and axis widths, divider step count, CORDIC step limit.
    localparam int CW      = 36;
    localparam int NW      = 24;
    localparam int DIV_N   = 24;
    localparam int MAXSTEP = 24;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_ZERO_X = 3'd0;
    localparam logic [2:0] CFG_ZERO_Y = 3'd1;
    localparam logic [2:0] CFG_ZERO_Z = 3'd2;
    localparam logic [2:0] CFG_ONE_X  = 3'd3;
    localparam logic [2:0] CFG_ONE_Y  = 3'd4;
    localparam logic [2:0] CFG_ONE_Z  = 3'd5;

    // Fixed-point constants.
    localparam logic signed [CW-1:0] PI_Q30   = 36'sd3373259426;
    localparam logic [29:0]          KINV_Q30 = 30'd652032874;
    localparam logic [7:0]           ROLL_MUL = 8'd147;
    localparam logic [5:0]           PITCH_MUL = 6'd59;
    localparam logic [19:0]          RECIP5   = 20'd838861;
    localparam logic [19:0]          ROLL_LIMIT  = 20'd47360;
    localparam logic [15:0]          PITCH_LIMIT = 16'd23808;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_COR1,
        ST_FIX,
        ST_GAIN1,
        ST_GAIN2,
        ST_LOAD2,
        ST_COR2,
        ST_SCALE1,
        ST_SCALE2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       div_step;
        logic       cor_load1;
        logic       cor_step;
        logic       fix;
        logic       gain1;
        logic       gain2;
        logic       cor_load2;
        logic       scale1;
        logic       scale2;
        logic       out_load;
        logic [4:0] step;
    } t_cmd;

    typedef struct packed {
        logic span_now;
        logic z_zero;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic [7:0] zero_x;
        logic [7:0] zero_y;
        logic [7:0] zero_z;
        logic [7:0] one_x;
        logic [7:0] one_y;
        logic [7:0] one_z;
    } t_cal;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133519495;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/accel_tilt_angles.sv =====
// One sample in flight: the input stays closed from the transaction until the result
// is loaded. A zero normalized z skips the CORDIC passes; a zero span skips the division
// as well. The next input is taken the cycle after the result is loaded, and a stalled
// output delays both the load and the next take.
// The 24-step divider lanes and the two shared CORDIC passes set the time per sample.
// Synchronous active-low reset clears calibration, held angles and control state.
// ----------------------------------------------------------------------------
// accel_tilt_angles
// Roll and pitch in Q8 from one calibrated three-axis accelerometer sample.
// ----------------------------------------------------------------------------
module accel_tilt_angles #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // sample_x, sample_y, sample_z
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // roll_angle[16:0], pitch_angle[32:17], zero pad
    output logic [1:0]  o_m_axis_tuser,   // angles_fresh, span_error
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);
    import ata_pkg::*;

    `include "accel_tilt_angles_assert.svh"

    t_cal  r_cal;
    t_cmd  cmd;
    t_stat stat;

    // Calibration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ZERO_X: r_cal.zero_x <= i_cfg_wdata;
                CFG_ZERO_Y: r_cal.zero_y <= i_cfg_wdata;
                CFG_ZERO_Z: r_cal.zero_z <= i_cfg_wdata;
                CFG_ONE_X:  r_cal.one_x  <= i_cfg_wdata;
                CFG_ONE_Y:  r_cal.one_y  <= i_cfg_wdata;
                CFG_ONE_Z:  r_cal.one_z  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    ata_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_axis_tvalid), .o_s_tready(o_s_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    ata_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cal(r_cal),
        .i_sample(i_s_axis_tdata), .i_m_tready(i_m_axis_tready), .o_stat(stat),
        .o_m_tvalid(o_m_axis_tvalid), .o_m_tdata(o_m_axis_tdata),
        .o_m_tuser(o_m_axis_tuser)
    );

    // A taken sample keeps the input side closed on the next cycle.
    `ATA_ASSERT_NEXT(a_busy_after_take, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    // A zero calibration span never reports recomputed angles.
    `ATA_ASSERT_SAME(a_span_not_fresh, o_m_axis_tvalid && o_m_axis_tuser[1], !o_m_axis_tuser[0])
    // Roll on the output stays inside its clamp range.
    `ATA_ASSERT_SAME(a_roll_range, o_m_axis_tvalid, ($signed(o_m_axis_tdata[16:0]) <= 17'sd47360) && ($signed(o_m_axis_tdata[16:0]) >= -17'sd47360))

endmodule

// ===== hdl/ata_div.sv =====
// ----------------------------------------------------------------------------
// ata_div
// One axis lane: restoring divider that normalizes (sample - zero) against
// (one - zero) into saturated signed Q8.16, one quotient bit per cycle while i_step is high.
// ----------------------------------------------------------------------------
module ata_div (
    input  logic                       i_clk,
    input  logic                       i_start,
    input  logic                       i_step,
    input  logic [7:0]                 i_sample,
    input  logic [7:0]                 i_zero,
    input  logic [7:0]                 i_one,
    output logic signed [ata_pkg::NW-1:0] o_norm
);
    import ata_pkg::*;

    logic signed [8:0] num;
    logic signed [8:0] den;
    logic [7:0]        an;
    logic [7:0]        ad;
    logic [8:0]        trial;

    logic [NW-1:0]     r_quo;
    logic [7:0]        r_rem;
    logic [7:0]        r_den;
    logic              r_neg;

    // Magnitudes and sign of the quotient.
    always_comb begin
        num   = $signed({1'b0, i_sample}) - $signed({1'b0, i_zero});
        den   = $signed({1'b0, i_one}) - $signed({1'b0, i_zero});
        an    = num[8] ? 8'(-num) : num[7:0];
        ad    = den[8] ? 8'(-den) : den[7:0];
        trial = {r_rem, r_quo[NW-1]};
    end

    // Shift the dividend out and the quotient in, one bit per step.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= {an, 16'h0000};
            r_rem <= '0;
            r_den <= ad;
            r_neg <= num[8] ^ den[8];
        end else if (i_step) begin
            if (trial >= {1'b0, r_den}) begin
                r_rem <= 8'(trial - {1'b0, r_den});
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= trial[7:0];
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    // Apply the sign and saturate to the Q8.16 range.
    always_comb begin
        if (r_neg) begin
            if (r_quo > 24'h800000) begin
                o_norm = 24'sh800000;
            end else begin
                o_norm = $signed(24'(-r_quo));
            end
        end else begin
            if (r_quo > 24'h7FFFFF) begin
                o_norm = 24'sh7FFFFF;
            end else begin
                o_norm = $signed(r_quo);
            end
        end
    end

endmodule

// ===== hdl/ata_datapath.sv =====
// ----------------------------------------------------------------------------
// ata_datapath
// Normalization lanes, shared vectoring CORDIC, gain correction, output
// scaling, held angles and the output register.
// ----------------------------------------------------------------------------
module ata_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ata_pkg::t_cmd        i_cmd,
    input  ata_pkg::t_cal        i_cal,
    input  logic [23:0]          i_sample,
    input  logic                 i_m_tready,
    output ata_pkg::t_stat       o_stat,
    output logic                 o_m_tvalid,
    output logic [39:0]          o_m_tdata,
    output logic [1:0]           o_m_tuser
);
    import ata_pkg::*;

    logic signed [NW-1:0] norm_x, norm_y, norm_z;
    logic span_now;

    logic signed [CW-1:0] r_x, r_y, r_a;
    logic signed [CW-1:0] r_roll_ang;
    logic [63:0]          r_acc;
    logic                 r_z_neg, r_x_pos, r_span, r_fresh;
    logic [21:0]          r_roll_t;
    logic                 r_roll_neg, r_pitch_neg;
    logic [15:0]          r_pitch_mag;
    logic signed [16:0]   r_held_roll;
    logic signed [15:0]   r_held_pitch;
    logic                 r_out_valid;
    logic [39:0]          r_out_data;
    logic [1:0]           r_out_user;

    logic signed [CW-1:0] ext_x, ext_y, ext_z;
    logic signed [CW-1:0] dx, dy, atan_ext;
    logic [CW-2:0]        roll_abs, pitch_abs;
    logic [42:0]          roll_prod;
    logic [36:0]          pitch_prod;
    logic [41:0]          roll_quot;
    logic [19:0]          roll_mag;
    logic [15:0]          pitch_sat;
    logic [19:0]          roll_sat;

    // Three normalization lanes run side by side.
    ata_div u_div_x (
        .i_clk(i_clk), .i_start(i_cmd.accept), .i_step(i_cmd.div_step),
        .i_sample(i_sample[7:0]), .i_zero(i_cal.zero_x), .i_one(i_cal.one_x),
        .o_norm(norm_x)
    );
    ata_div u_div_y (
        .i_clk(i_clk), .i_start(i_cmd.accept), .i_step(i_cmd.div_step),
        .i_sample(i_sample[15:8]), .i_zero(i_cal.zero_y), .i_one(i_cal.one_y),
        .o_norm(norm_y)
    );
    ata_div u_div_z (
        .i_clk(i_clk), .i_start(i_cmd.accept), .i_step(i_cmd.div_step),
        .i_sample(i_sample[23:16]), .i_zero(i_cal.zero_z), .i_one(i_cal.one_z),
        .o_norm(norm_z)
    );

    assign span_now = (i_cal.one_x == i_cal.zero_x) || (i_cal.one_y == i_cal.zero_y)
                   || (i_cal.one_z == i_cal.zero_z);

    assign o_stat.span_now = span_now;
    assign o_stat.z_zero   = (norm_z == '0);
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    // CORDIC operands and the scaling products.
    always_comb begin
        ext_x     = CW'(norm_x) <<< 8;
        ext_y     = CW'(norm_y) <<< 8;
        ext_z     = CW'(norm_z) <<< 8;
        dx        = r_y >>> i_cmd.step;
        dy        = r_x >>> i_cmd.step;
        atan_ext  = $signed({6'b0, atan_q30(i_cmd.step)});
        roll_abs  = r_roll_ang[CW-1] ? (CW-1)'(-r_roll_ang) : r_roll_ang[CW-2:0];
        pitch_abs = r_a[CW-1] ? (CW-1)'(-r_a) : r_a[CW-2:0];
        roll_prod  = 43'(roll_abs) * 43'(ROLL_MUL) + 43'(5 << 20);
        pitch_prod = 37'(pitch_abs) * 37'(PITCH_MUL) + 37'(1 << 21);
        roll_quot  = 42'(r_roll_t) * 42'(RECIP5);
        roll_mag   = roll_quot[41:22];
        roll_sat   = (roll_mag > ROLL_LIMIT) ? ROLL_LIMIT : roll_mag;
        pitch_sat  = (pitch_prod[36:22] > 15'(PITCH_LIMIT)) ? PITCH_LIMIT
                                                             : {1'b0, pitch_prod[36:22]};
    end

    // Vectoring CORDIC registers, shared by the roll and pitch passes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cor_load1) begin
            r_x <= norm_z[NW-1] ? -ext_z : ext_z;
            r_y <= norm_z[NW-1] ? -ext_x : ext_x;
            r_a <= '0;
        end else if (i_cmd.cor_load2) begin
            r_x <= $signed({2'b00, r_acc[63:30]});
            r_y <= ext_y;
            r_a <= '0;
        end else if (i_cmd.cor_step) begin
            if (!r_y[CW-1]) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_a <= r_a + atan_ext;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_a <= r_a - atan_ext;
            end
        end else if (i_cmd.fix) begin
            r_a <= r_z_neg ? (r_x_pos ? r_a + PI_Q30 : r_a - PI_Q30) : r_a;
        end
    end

    // Quadrant flags, gain correction and scaling stages.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cor_load1) begin
            r_z_neg <= norm_z[NW-1];
            r_x_pos <= !norm_x[NW-1] && (norm_x != '0);
        end
        if (i_cmd.gain1) begin
            r_roll_ang <= r_a;
            r_acc      <= 64'(r_x[16:0]) * 64'(KINV_Q30);
        end
        if (i_cmd.gain2) begin
            r_acc <= r_acc + ((64'(r_x[33:17]) * 64'(KINV_Q30)) << 17);
        end
        if (i_cmd.scale1) begin
            r_roll_t    <= roll_prod[42:21];
            r_roll_neg  <= r_roll_ang[CW-1];
            r_pitch_mag <= pitch_sat;
            r_pitch_neg <= r_a[CW-1];
        end
    end

    // Control flags and held angles.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_roll  <= '0;
            r_held_pitch <= '0;
            r_fresh      <= 1'b0;
            r_span       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_fresh <= 1'b0;
                r_span  <= span_now;
            end
            if (i_cmd.scale2) begin
                r_fresh      <= 1'b1;
                r_held_roll  <= r_roll_neg ? -$signed({1'b0, roll_sat[15:0]})
                                           : $signed({1'b0, roll_sat[15:0]});
                r_held_pitch <= r_pitch_neg ? $signed(r_pitch_mag) : -$signed(r_pitch_mag);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {7'b0, r_held_pitch, r_held_roll};
            r_out_user <= {r_span, r_fresh};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

// ===== hdl/ata_ctrl.sv =====
// ----------------------------------------------------------------------------
// ata_ctrl
// Sequencer for one sample: divide, roll CORDIC, fix, gain, pitch CORDIC,
// scale, output register. Zero span or zero normalized z jumps to the output.
// ----------------------------------------------------------------------------
module ata_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  ata_pkg::t_stat i_stat,
    output ata_pkg::t_cmd  o_cmd
);
    import ata_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < MAXSTEP) ? CORDIC_STEPS : MAXSTEP;
    localparam logic [4:0] LAST_COR = 5'(NSTEP - 1);
    localparam logic [4:0] LAST_DIV = 5'(DIV_N - 1);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       take;

    assign take = i_s_tvalid && (r_state == ST_IDLE);

    // Next state and step counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (take) begin
                    n_state = i_stat.span_now ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == LAST_DIV) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_cnt   = '0;
                n_state = i_stat.z_zero ? ST_OUT : ST_COR1;
            end
            ST_COR1: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == LAST_COR) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX:   n_state = ST_GAIN1;
            ST_GAIN1: n_state = ST_GAIN2;
            ST_GAIN2: n_state = ST_LOAD2;
            ST_LOAD2: begin
                n_cnt   = '0;
                n_state = ST_COR2;
            end
            ST_COR2: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == LAST_COR) begin
                    n_state = ST_SCALE1;
                end
            end
            ST_SCALE1: n_state = ST_SCALE2;
            ST_SCALE2: n_state = ST_OUT;
            ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath commands decoded from the state.
    always_comb begin
        o_cmd           = '0;
        o_cmd.step      = r_cnt;
        o_cmd.accept    = take;
        o_cmd.div_step  = (r_state == ST_DIV);
        o_cmd.cor_load1 = (r_state == ST_CHECK) && !i_stat.z_zero;
        o_cmd.cor_step  = (r_state == ST_COR1) || (r_state == ST_COR2);
        o_cmd.fix       = (r_state == ST_FIX);
        o_cmd.gain1     = (r_state == ST_GAIN1);
        o_cmd.gain2     = (r_state == ST_GAIN2);
        o_cmd.cor_load2 = (r_state == ST_LOAD2);
        o_cmd.scale1    = (r_state == ST_SCALE1);
        o_cmd.scale2    = (r_state == ST_SCALE2);
        o_cmd.out_load  = (r_state == ST_OUT) && i_stat.out_free;
        o_s_tready      = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
